@@ rtl/core/htd_pkg.sv @@
// Shared constants, node layout and controller/datapath interface types.
`default_nettype none

package htd_pkg;

  localparam int MAX_CODES    = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_DEPTH   = 2 * MAX_CODES;
  localparam int NODE_W       = $clog2(NODE_DEPTH);
  localparam int NFREE_W      = NODE_W + 1;

  localparam int KIND_W = 2;
  localparam int SYM_W  = 16;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int CIDX_W = $clog2(CODE_W);
  localparam int BYTE_W = 8;
  localparam int BV_W   = 4;
  localparam int CNT_W  = 4;
  localparam int POS_W  = 6;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  sym;
  } node_t;

  typedef struct packed {
    logic clear;
    logic cap_ins;
    logic cap_dec;
    logic rd_walk;
    logic use_byte;
    logic ins_desc;
    logic ins_load;
    logic ins_wsym;
    logic ins_link;
    logic ins_alloc;
    logic set_ovf;
    logic dec_load;
    logic dec_step;
    logic dec_resolve;
    logic flush;
  } htd_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic bv_zero;
    logic child_zero;
    logic fits;
    logic pos_zero;
    logic pos_one;
    logic cnt_one;
    logic cnt_zero;
  } htd_status_t;

endpackage

`default_nettype wire

@@ rtl/core/huffman_tree_decoder.sv @@
// Top level of the Huffman tree decoder: controller plus datapath.
`default_nettype none

// An item is taken when start is high and busy is low. A clear item, a
// codebook entry with an unusable length, a data byte with no valid bits and
// an unknown kind complete in their transfer cycle and never raise busy. A
// codebook item walks the existing path with a step state and a wait state
// per level (one node store read each); at the first missing child the step
// state makes the capacity check, which on failure sets overflow and ends the
// item, then a link state writes the parent and an alloc state writes each
// new node. A data byte passes a reload of the walk position, then per valid
// bit a bit state, followed by a wait state when the bit descends to a stored
// node (node store read latency), and a final flush state. Each result
// appears for exactly one cycle with valid_o high and the receiver cannot
// stall it; results of a byte come out in order, the final one with last_o
// set in the first cycle after busy falls.

module huffman_tree_decoder import htd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [LEN_W-1:0]  code_len_i,
  input  wire logic [CODE_W-1:0] code_bits_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [BV_W-1:0]   bits_valid_i,
  output logic                   valid_o,
  output logic [SYM_W-1:0]       decoded_symbol_o,
  output logic                   bad_code_o,
  output logic                   overflow_o,
  output logic                   last_o
);

  htd_cmd_t    cmd;
  htd_status_t status;

  htd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .kind_i  (kind_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  htd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .symbol_i        (symbol_i),
    .code_len_i      (code_len_i),
    .code_bits_i     (code_bits_i),
    .data_byte_i     (data_byte_i),
    .bits_valid_i    (bits_valid_i),
    .valid_o         (valid_o),
    .decoded_symbol_o(decoded_symbol_o),
    .bad_code_o      (bad_code_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/htd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htd_ram #(
  parameter int Width = 34,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/htd_ctrl.sv @@
// Controller state machine for tree insertion and bit-serial decoding.
`default_nettype none

module htd_ctrl import htd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire htd_status_t       status_i,
  output htd_cmd_t               cmd_o,
  output logic                   busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_STEP  = 4'd1;
  localparam logic [3:0] S_INS_WAIT  = 4'd2;
  localparam logic [3:0] S_INS_LINK  = 4'd3;
  localparam logic [3:0] S_INS_ALLOC = 4'd4;
  localparam logic [3:0] S_DEC_LOADW = 4'd5;
  localparam logic [3:0] S_DEC_BIT   = 4'd6;
  localparam logic [3:0] S_DEC_WAIT  = 4'd7;
  localparam logic [3:0] S_DEC_END   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.rd_walk = 1'b1;
        if (start) begin
          case (kind_i)
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            KIND_CODE: begin
              if (status_i.len_ok) begin
                cmd_o.cap_ins = 1'b1;
                state_d       = S_INS_STEP;
              end
            end
            KIND_DATA: begin
              if (!status_i.bv_zero) begin
                cmd_o.cap_dec = 1'b1;
                state_d       = S_DEC_LOADW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_STEP: begin
        if (!status_i.child_zero) begin
          cmd_o.ins_desc = 1'b1;
          state_d        = S_INS_WAIT;
        end else if (status_i.fits) begin
          state_d = S_INS_LINK;
        end else begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_INS_WAIT: begin
        cmd_o.ins_load = 1'b1;
        if (status_i.pos_zero) begin
          cmd_o.ins_wsym = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_INS_STEP;
        end
      end
      S_INS_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d        = S_INS_ALLOC;
      end
      S_INS_ALLOC: begin
        cmd_o.ins_alloc = 1'b1;
        if (status_i.pos_one) begin
          state_d = S_IDLE;
        end
      end
      S_DEC_LOADW: begin
        cmd_o.dec_load = 1'b1;
        state_d        = S_DEC_BIT;
      end
      S_DEC_BIT: begin
        cmd_o.use_byte = 1'b1;
        cmd_o.dec_step = 1'b1;
        if (status_i.child_zero) begin
          state_d = status_i.cnt_one ? S_DEC_END : S_DEC_BIT;
        end else begin
          state_d = S_DEC_WAIT;
        end
      end
      S_DEC_WAIT: begin
        cmd_o.dec_resolve = 1'b1;
        state_d           = status_i.cnt_zero ? S_DEC_END : S_DEC_BIT;
      end
      S_DEC_END: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/htd_datapath.sv @@
// Datapath: tree registers, node store, walk position and result staging.
`default_nettype none

module htd_datapath import htd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire htd_cmd_t          cmd_i,
  output htd_status_t            status_o,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [LEN_W-1:0]  code_len_i,
  input  wire logic [CODE_W-1:0] code_bits_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [BV_W-1:0]   bits_valid_i,
  output logic                   valid_o,
  output logic [SYM_W-1:0]       decoded_symbol_o,
  output logic                   bad_code_o,
  output logic                   overflow_o,
  output logic                   last_o
);

  // Tree control state.
  logic [NODE_W-1:0]  root_l_q, root_r_q;
  logic [NFREE_W-1:0] nf_q;
  logic [NODE_W-1:0]  walk_q;
  logic               ovf_q;
  logic               pend_v_q;
  logic               valid_q;

  // Working registers.
  node_t              cur_q;
  logic [NODE_W-1:0]  cur_idx_q;
  logic [NODE_W-1:0]  cand_q;
  logic [SYM_W-1:0]   sym_q;
  logic [CODE_W-1:0]  code_q;
  logic [POS_W-1:0]   pos_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SYM_W-1:0]   pend_sym_q;
  logic               pend_bad_q;
  logic               pend_ovf_q;
  logic [SYM_W-1:0]   out_sym_q;
  logic               out_bad_q;
  logic               out_ovf_q;
  logic               out_last_q;

  node_t              rdata;
  node_t              wdata;
  node_t              root_node;
  logic               we;
  logic [NODE_W-1:0]  waddr;
  logic [NODE_W-1:0]  raddr;
  logic [POS_W-1:0]   pos_m1;
  logic [POS_W-1:0]   pos_m2;
  logic               ins_bit;
  logic               step_bit;
  logic [NODE_W-1:0]  child;
  logic [NODE_W-1:0]  nf_node;
  logic [NODE_W-1:0]  nf_next;
  logic               leaf;
  logic               new_v;
  logic [SYM_W-1:0]   new_sym;
  logic               new_bad;

  assign root_node = '{left: root_l_q, right: root_r_q, sym: '0};
  assign pos_m1    = pos_q - POS_W'(1);
  assign pos_m2    = pos_q - POS_W'(2);
  assign ins_bit   = code_q[pos_m1[CIDX_W-1:0]];
  assign step_bit  = cmd_i.use_byte ? byte_q[BYTE_W-1] : ins_bit;
  assign child     = step_bit ? cur_q.right : cur_q.left;
  assign nf_node   = nf_q[NODE_W-1:0];
  assign nf_next   = nf_node + NODE_W'(1);
  assign leaf      = (rdata.left == '0) && (rdata.right == '0);
  assign raddr     = cmd_i.rd_walk ? walk_q : child;

  always_comb begin
    status_o            = '0;
    status_o.len_ok     = (code_len_i != '0) && (code_len_i <= LEN_W'(MAX_CODE_LEN))
                          && (code_len_i <= LEN_W'(CODE_W));
    status_o.bv_zero    = (bits_valid_i == '0);
    status_o.child_zero = (child == '0);
    // The missing nodes of the path must all fit below the store depth.
    status_o.fits       = ({1'b0, nf_q} + (NFREE_W + 1)'(pos_q))
                          <= (NFREE_W + 1)'(NODE_DEPTH);
    status_o.pos_zero   = (pos_q == '0);
    status_o.pos_one    = (pos_q == POS_W'(1));
    status_o.cnt_one    = (cnt_q == CNT_W'(1));
    status_o.cnt_zero   = (cnt_q == '0);
  end

  // Node store writes: symbol update, parent link, or a freshly allocated node.
  always_comb begin
    we    = 1'b0;
    waddr = cand_q;
    wdata = cur_q;
    if (cmd_i.ins_wsym) begin
      we    = 1'b1;
      waddr = cand_q;
      wdata = '{left: rdata.left, right: rdata.right, sym: sym_q};
    end else if (cmd_i.ins_link && (cur_idx_q != '0)) begin
      we    = 1'b1;
      waddr = cur_idx_q;
      wdata = cur_q;
      if (ins_bit) begin
        wdata.right = nf_node;
      end else begin
        wdata.left = nf_node;
      end
    end else if (cmd_i.ins_alloc) begin
      we    = 1'b1;
      waddr = nf_node;
      wdata = '0;
      if (pos_q == POS_W'(1)) begin
        wdata.sym = sym_q;
      end else if (code_q[pos_m2[CIDX_W-1:0]]) begin
        wdata.right = nf_next;
      end else begin
        wdata.left = nf_next;
      end
    end
  end

  htd_ram #(
    .Width($bits(node_t)),
    .Depth(NODE_DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    new_v   = 1'b0;
    new_sym = '0;
    new_bad = 1'b0;
    if (cmd_i.dec_step && (child == '0)) begin
      new_v   = 1'b1;
      new_bad = 1'b1;
    end else if (cmd_i.dec_resolve && leaf) begin
      new_v   = 1'b1;
      new_sym = rdata.sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_l_q <= '0;
      root_r_q <= '0;
      nf_q     <= NFREE_W'(1);
      walk_q   <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cmd_i.clear) begin
        root_l_q <= '0;
        root_r_q <= '0;
        nf_q     <= NFREE_W'(1);
        walk_q   <= '0;
        ovf_q    <= 1'b0;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.ins_link && (cur_idx_q == '0)) begin
        if (ins_bit) begin
          root_r_q <= nf_node;
        end else begin
          root_l_q <= nf_node;
        end
      end
      if (cmd_i.ins_alloc) begin
        nf_q <= nf_q + NFREE_W'(1);
      end
      if (cmd_i.dec_step && (child == '0)) begin
        walk_q <= '0;
      end
      if (cmd_i.dec_resolve) begin
        walk_q <= leaf ? '0 : cand_q;
      end
      // A result is held back until the next one or the end of the byte,
      // so the final transfer of a byte can carry last.
      if (new_v) begin
        pend_v_q <= 1'b1;
        valid_q  <= pend_v_q;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
        valid_q  <= pend_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_ins) begin
      sym_q     <= symbol_i;
      code_q    <= code_bits_i;
      pos_q     <= POS_W'(code_len_i);
      cur_q     <= root_node;
      cur_idx_q <= '0;
    end
    if (cmd_i.cap_dec) begin
      byte_q <= data_byte_i;
      cnt_q  <= (bits_valid_i > BV_W'(BYTE_W)) ? CNT_W'(BYTE_W) : bits_valid_i[CNT_W-1:0];
    end
    if (cmd_i.ins_desc) begin
      cand_q <= child;
      pos_q  <= pos_m1;
    end
    if (cmd_i.ins_load) begin
      cur_q     <= rdata;
      cur_idx_q <= cand_q;
    end
    if (cmd_i.ins_alloc) begin
      pos_q <= pos_m1;
    end
    if (cmd_i.dec_load) begin
      cur_q <= (walk_q == '0) ? root_node : rdata;
    end
    if (cmd_i.dec_step) begin
      byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
      cnt_q  <= cnt_q - CNT_W'(1);
      cand_q <= child;
      if (child == '0) begin
        cur_q <= root_node;
      end
    end
    if (cmd_i.dec_resolve) begin
      cur_q <= leaf ? root_node : rdata;
    end
    if (new_v) begin
      pend_sym_q <= new_sym;
      pend_bad_q <= new_bad;
      pend_ovf_q <= ovf_q;
      out_sym_q  <= pend_sym_q;
      out_bad_q  <= pend_bad_q;
      out_ovf_q  <= pend_ovf_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_sym_q  <= pend_sym_q;
      out_bad_q  <= pend_bad_q;
      out_ovf_q  <= pend_ovf_q;
      out_last_q <= 1'b1;
    end
  end

  assign valid_o          = valid_q;
  assign decoded_symbol_o = out_sym_q;
  assign bad_code_o       = out_bad_q;
  assign overflow_o       = out_ovf_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

@@ bench/tb_huffman_tree_decoder.sv @@
// Testbench for the Huffman tree decoder: random and directed items against a scoreboard.
`timescale 1ns / 1ps

module tb_huffman_tree_decoder;
  import htd_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_len;
    logic [CODE_W-1:0] code_bits;
    logic [BYTE_W-1:0] data_byte;
    logic [BV_W-1:0]   bits_valid;
  } htd_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             bad;
    logic             ovf;
    logic             last;
  } sym_result_t;

  // Tracks its own copy of the code tree and the symbols each byte should yield.
  class symbol_scoreboard;
    logic [NODE_W-1:0] left_child [NODE_DEPTH];
    logic [NODE_W-1:0] right_child [NODE_DEPTH];
    logic [SYM_W-1:0]  node_symbol [NODE_DEPTH];
    logic [NODE_W-1:0] root_left;
    logic [NODE_W-1:0] root_right;
    logic [NODE_W-1:0] walk_pos;
    int                free_node;
    bit                overflow;
    sym_result_t       expected_symbols[$];
    int                errors;

    function new();
      errors = 0;
      clear_tree();
    endfunction

    function void clear_tree();
      root_left  = '0;
      root_right = '0;
      walk_pos   = '0;
      free_node  = 1;
      overflow   = 1'b0;
    endfunction

    function logic [NODE_W-1:0] child(logic [NODE_W-1:0] node, logic b);
      if (node == '0) return b ? root_right : root_left;
      return b ? right_child[node] : left_child[node];
    endfunction

    function void link_child(logic [NODE_W-1:0] node, logic b, logic [NODE_W-1:0] c);
      if (node == '0) begin
        if (b) root_right = c;
        else root_left = c;
      end else if (b) begin
        right_child[node] = c;
      end else begin
        left_child[node] = c;
      end
    endfunction

    function void insert_code(logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                              logic [CODE_W-1:0] code);
      int missing;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] c;
      logic b;
      if (len == '0 || len > MAX_CODE_LEN) return;
      // Count the nodes the path still needs; once one is missing, all below are.
      missing = 0;
      node = '0;
      for (int i = 0; i < len; i++) begin
        b = code[len - 1 - i];
        c = (missing == 0) ? child(node, b) : '0;
        if (c == '0) missing++;
        else node = c;
      end
      if (free_node + missing > NODE_DEPTH) begin
        overflow = 1'b1;
        return;
      end
      node = '0;
      for (int i = 0; i < len; i++) begin
        b = code[len - 1 - i];
        c = child(node, b);
        if (c == '0) begin
          c = free_node[NODE_W-1:0];
          free_node++;
          left_child[c]  = '0;
          right_child[c] = '0;
          node_symbol[c] = '0;
          link_child(node, b, c);
        end
        node = c;
      end
      node_symbol[node] = sym;
    endfunction

    function void decode_byte(logic [BYTE_W-1:0] data, logic [BV_W-1:0] bv);
      sym_result_t found[$];
      sym_result_t r;
      logic [NODE_W-1:0] nxt;
      int count;
      count = (bv > 8) ? 8 : int'(bv);
      for (int i = 0; i < count; i++) begin
        nxt = child(walk_pos, data[7 - i]);
        if (nxt == '0) begin
          r = '{symbol: '0, bad: 1'b1, ovf: overflow, last: 1'b0};
          found = {found, r};
          walk_pos = '0;
        end else if (left_child[nxt] == '0 && right_child[nxt] == '0) begin
          r = '{symbol: node_symbol[nxt], bad: 1'b0, ovf: overflow, last: 1'b0};
          found = {found, r};
          walk_pos = '0;
        end else begin
          walk_pos = nxt;
        end
      end
      for (int k = 0; k < found.size(); k++) begin
        r = found[k];
        r.last = (k == found.size() - 1);
        expected_symbols = {expected_symbols, r};
      end
    endfunction

    function void accept_item(htd_item_t it);
      case (it.kind)
        KIND_CLEAR: clear_tree();
        KIND_CODE:  insert_code(it.symbol, it.code_len, it.code_bits);
        KIND_DATA:  decode_byte(it.data_byte, it.bits_valid);
        default:    ;
      endcase
    endfunction

    function void check_symbol(sym_result_t got);
      sym_result_t want;
      if (expected_symbols.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Unexpected result: symbol=%h bad=%b ovf=%b last=%b",
                   got.symbol, got.bad, got.ovf, got.last);
        return;
      end
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol || got.bad !== want.bad ||
          got.ovf !== want.ovf || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display({"Mismatch: expected symbol=%h bad=%b ovf=%b last=%b, ",
                    "got symbol=%h bad=%b ovf=%b last=%b"},
                   want.symbol, want.bad, want.ovf, want.last,
                   got.symbol, got.bad, got.ovf, got.last);
      end
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] kind_i = '0;
  logic [SYM_W-1:0]  symbol_i = '0;
  logic [LEN_W-1:0]  code_len_i = '0;
  logic [CODE_W-1:0] code_bits_i = '0;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic [BV_W-1:0]   bits_valid_i = '0;
  logic              valid_o;
  logic [SYM_W-1:0]  decoded_symbol_o;
  logic              bad_code_o;
  logic              overflow_o;
  logic              last_o;

  symbol_scoreboard sb;
  int               idle_pct = 30;
  int               sent = 0;
  int               stall_cycles = 0;
  bit               progress;
  sym_result_t      got_res;
  htd_item_t        acc_item;

  huffman_tree_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .symbol_i         (symbol_i),
    .code_len_i       (code_len_i),
    .code_bits_i      (code_bits_i),
    .data_byte_i      (data_byte_i),
    .bits_valid_i     (bits_valid_i),
    .valid_o          (valid_o),
    .decoded_symbol_o (decoded_symbol_o),
    .bad_code_o       (bad_code_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (valid_o) begin
        got_res.symbol = decoded_symbol_o;
        got_res.bad    = bad_code_o;
        got_res.ovf    = overflow_o;
        got_res.last   = last_o;
        sb.check_symbol(got_res);
        progress = 1'b1;
      end
      if (start && !busy) begin
        acc_item.kind       = kind_i;
        acc_item.symbol     = symbol_i;
        acc_item.code_len   = code_len_i;
        acc_item.code_bits  = code_bits_i;
        acc_item.data_byte  = data_byte_i;
        acc_item.bits_valid = bits_valid_i;
        sb.accept_item(acc_item);
        progress = 1'b1;
      end
      if (progress) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic htd_item_t make_item(logic [KIND_W-1:0] kind);
    htd_item_t it;
    it.kind       = kind;
    it.symbol     = SYM_W'($urandom_range(16'hFFFF));
    it.code_len   = LEN_W'($urandom_range(63));
    it.code_bits  = $urandom;
    it.data_byte  = BYTE_W'($urandom_range(255));
    it.bits_valid = BV_W'($urandom_range(15));
    return it;
  endfunction

  function automatic htd_item_t data_item();
    htd_item_t it;
    it = make_item(KIND_DATA);
    if ($urandom_range(9) < 7) it.bits_valid = 4'd8;
    return it;
  endfunction

  function automatic htd_item_t code_item(logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                                          logic [CODE_W-1:0] code);
    htd_item_t it;
    it = make_item(KIND_CODE);
    it.symbol    = sym;
    it.code_len  = len;
    it.code_bits = code;
    return it;
  endfunction

  function automatic htd_item_t byte_item(logic [BYTE_W-1:0] data, logic [BV_W-1:0] bv);
    htd_item_t it;
    it = make_item(KIND_DATA);
    it.data_byte  = data;
    it.bits_valid = bv;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_item(htd_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    kind_i       <= it.kind;
    symbol_i     <= it.symbol;
    code_len_i   <= it.code_len;
    code_bits_i  <= it.code_bits;
    data_byte_i  <= it.data_byte;
    bits_valid_i <= it.bits_valid;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.kind != KIND_NONE &&
        !(it.kind == KIND_CODE && (it.code_len == '0 || it.code_len > MAX_CODE_LEN)))
      sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One session: usually a complete prefix code and a stream over it, with some
  // entries dropped and junk mixed in. A flood session overfills the node store.
  task automatic play_session(bit flood);
    logic [LEN_W-1:0]  lens[$];
    logic [CODE_W-1:0] codes[$];
    htd_item_t it;
    int target;
    int j;
    bit deep;
    if (flood) begin
      send_item(make_item(KIND_CLEAR));
      repeat ($urandom_range(17, 22)) begin
        it = make_item(KIND_CODE);
        it.code_len = 6'd32;
        send_item(it);
      end
      repeat ($urandom_range(3, 8)) send_item(data_item());
      return;
    end
    deep = ($urandom_range(5) == 0);
    target = deep ? 40 : $urandom_range(2, 14);
    lens = {6'd1, 6'd1};
    codes = {32'd0, 32'd1};
    // Splitting a leaf into two children keeps the code complete.
    while (lens.size() < target) begin
      j = deep ? lens.size() - 1 : $urandom_range(lens.size() - 1);
      if (lens[j] == 6'd32) break;
      lens[j] = lens[j] + 6'd1;
      codes[j] = codes[j] << 1;
      lens = {lens, lens[j]};
      codes = {codes, codes[j] | 32'd1};
    end
    if ($urandom_range(7) != 0) send_item(make_item(KIND_CLEAR));
    while (lens.size() != 0) begin
      j = $urandom_range(lens.size() - 1);
      if ($urandom_range(11) != 0)
        send_item(code_item(SYM_W'($urandom_range(16'hFFFF)), lens[j], codes[j]));
      lens.delete(j);
      codes.delete(j);
      if ($urandom_range(9) == 0) send_item(make_item(KIND_CODE));
    end
    repeat ($urandom_range(3, 12)) begin
      if ($urandom_range(15) == 0) send_item(make_item(KIND_W'($urandom_range(3))));
      send_item(data_item());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty tree, field extremes, inner-node symbols, crossed leaves.
    send_item(byte_item(8'hA5, 4'd8));
    send_item(code_item(16'hFFFF, 6'd1, 32'h0));
    send_item(code_item(16'h0000, 6'd2, 32'h2));
    send_item(code_item(16'h1234, 6'd3, 32'h6));
    send_item(code_item(16'h5678, 6'd2, 32'h3));
    send_item(code_item(16'h4321, 6'd3, 32'h7));
    send_item(code_item(16'h9999, 6'd4, 32'hC));
    send_item(code_item(16'h7777, 6'd0, 32'h1));
    send_item(code_item(16'h7777, 6'd33, 32'h1));
    send_item(code_item(16'h7777, 6'd63, 32'hFFFF_FFFF));
    send_item(code_item(16'h8001, 6'd32, 32'hFFFF_FFFF));
    send_item(byte_item(8'h00, 4'd8));
    send_item(byte_item(8'hFF, 4'd8));
    send_item(byte_item(8'hFF, 4'd15));
    send_item(byte_item(8'hFF, 4'd9));
    send_item(byte_item(8'hFF, 4'd8));
    send_item(byte_item(8'h5A, 4'd0));
    send_item(make_item(KIND_NONE));
    send_item(byte_item(8'h96, 4'd1));
    send_item(byte_item(8'h40, 4'd3));
    send_item(byte_item(8'hD0, 4'd5));
    send_item(make_item(KIND_CLEAR));
    send_item(byte_item(8'hFF, 4'd8));
    send_item(code_item(16'h00FF, 6'd1, 32'h1));
    send_item(byte_item(8'h80, 4'd2));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
      if (phase == 0) play_session(1'b1);
      while (sent < 25 + (phase + 1) * 152) play_session($urandom_range(9) == 0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
